// ----- rtl/adm_pkg.sv -----
// ----------------------------------------------------------------------------
// adm_pkg
// Shared types and constants for the manufacturer-data filter.
// ----------------------------------------------------------------------------
package adm_pkg;

    // Report lengths above this are clamped
    localparam logic [7:0] ADM_MAX_REPORT_BYTES = 8'd255;
    // Result queue depth between the parser and the output side
    localparam int         ADM_QUEUE_DEPTH      = 4;

    localparam logic [7:0] ADM_TYPE_MANUF       = 8'hFF;  // manufacturer-specific AD type
    localparam logic [7:0] ADM_MIN_MANUF_LEN    = 8'd3;   // type byte plus company id
    localparam logic [7:0] ADM_MIN_LEFT         = 8'd2;   // length byte plus one more

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_TYPE,
        PH_CO_LO,
        PH_CO_HI,
        PH_SKIP,
        PH_PAYLOAD
    } t_adm_phase;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              first_byte;
        logic [7:0]        report_length;
        logic              report_complete;
        logic signed [7:0] signal_strength;
        logic [47:0]       sender_address;
        logic [1:0]        address_kind;
    } t_adm_in;

    typedef struct packed {
        logic [7:0]        payload_byte;
        logic [7:0]        payload_index;
        logic              payload_last;
        logic              payload_empty;
        logic signed [7:0] match_rssi;
        logic [47:0]       match_address;
        logic [1:0]        match_address_kind;
        logic [31:0]       match_count;
    } t_adm_out;

endpackage

// ----- rtl/adm_parser.sv -----
// ----------------------------------------------------------------------------
// adm_parser
// Front end: walks the AD structures of a report one byte a cycle and
// produces at most one result beat per byte.
// ----------------------------------------------------------------------------
module adm_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  adm_pkg::t_adm_in i_item,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_wdata,
    output logic             o_res_valid,
    output adm_pkg::t_adm_out o_res
);
    import adm_pkg::*;

    logic [15:0]       r_mfr_id;
    logic [7:0]        r_left,  n_left;
    t_adm_phase        r_phase, n_phase;
    logic [7:0]        r_flen,  n_flen;
    logic [7:0]        r_foff,  n_foff;
    logic [7:0]        r_colo,  n_colo;
    logic signed [7:0] r_rssi,  n_rssi;
    logic [47:0]       r_addr,  n_addr;
    logic [1:0]        r_kind,  n_kind;
    logic [31:0]       r_count, n_count;

    // state as seen by this byte, after a first-byte reload
    logic [7:0]        e_left;
    t_adm_phase        e_phase;
    logic [7:0]        e_flen;
    logic [7:0]        e_foff;
    logic signed [7:0] e_rssi;
    logic [47:0]       e_addr;
    logic [1:0]        e_kind;

    logic [7:0] b;
    logic       co_match;
    logic [7:0] foff_inc;

    assign b        = i_item.data_byte;
    assign co_match = ({b, r_colo} == r_mfr_id);
    assign foff_inc = e_foff + 8'd1;

    always_comb begin
        if (i_valid && i_item.first_byte) begin
            e_left  = (i_item.report_length > ADM_MAX_REPORT_BYTES) ?
                      ADM_MAX_REPORT_BYTES : i_item.report_length;
            e_phase = i_item.report_complete ? PH_LEN : PH_IDLE;
            e_flen  = '0;
            e_foff  = '0;
            e_rssi  = i_item.signal_strength;
            e_addr  = i_item.sender_address;
            e_kind  = i_item.address_kind;
        end else begin
            e_left  = r_left;
            e_phase = r_phase;
            e_flen  = r_flen;
            e_foff  = r_foff;
            e_rssi  = r_rssi;
            e_addr  = r_addr;
            e_kind  = r_kind;
        end
    end

    // next state
    always_comb begin
        logic dec;
        dec     = 1'b0;
        n_left  = r_left;
        n_phase = r_phase;
        n_flen  = r_flen;
        n_foff  = r_foff;
        n_colo  = r_colo;
        n_rssi  = r_rssi;
        n_addr  = r_addr;
        n_kind  = r_kind;
        n_count = r_count;
        if (i_valid) begin
            n_left  = e_left;
            n_phase = e_phase;
            n_flen  = e_flen;
            n_foff  = e_foff;
            n_rssi  = e_rssi;
            n_addr  = e_addr;
            n_kind  = e_kind;
            unique case (e_phase)
                PH_IDLE: ;
                PH_LEN: begin
                    if (e_left < ADM_MIN_LEFT || b == 8'd0 ||
                        ({1'b0, b} + 9'd1) > {1'b0, e_left}) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_flen  = b;
                        n_foff  = '0;
                        n_phase = PH_TYPE;
                        dec     = 1'b1;
                    end
                end
                PH_TYPE: begin
                    n_foff = 8'd1;
                    dec    = 1'b1;
                    if (b == ADM_TYPE_MANUF && e_flen >= ADM_MIN_MANUF_LEN) begin
                        n_phase = PH_CO_LO;
                    end else begin
                        n_phase = (8'd1 >= e_flen) ? PH_LEN : PH_SKIP;
                    end
                end
                PH_CO_LO: begin
                    n_colo  = b;
                    n_foff  = 8'd2;
                    n_phase = PH_CO_HI;
                    dec     = 1'b1;
                end
                PH_CO_HI: begin
                    n_foff = 8'd3;
                    dec    = 1'b1;
                    if (co_match) begin
                        n_count = r_count + 32'd1;
                        n_phase = (e_flen == ADM_MIN_MANUF_LEN) ? PH_IDLE : PH_PAYLOAD;
                    end else begin
                        n_phase = (8'd3 >= e_flen) ? PH_LEN : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_foff  = foff_inc;
                    n_phase = (foff_inc >= e_flen) ? PH_LEN : PH_SKIP;
                    dec     = 1'b1;
                end
                PH_PAYLOAD: begin
                    n_foff = foff_inc;
                    dec    = 1'b1;
                    if (foff_inc >= e_flen) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
            if (dec && e_left != 8'd0) begin
                n_left = e_left - 8'd1;
            end
        end
    end

    // result beat
    always_comb begin
        o_res_valid                = 1'b0;
        o_res.payload_byte         = '0;
        o_res.payload_index        = '0;
        o_res.payload_last         = 1'b0;
        o_res.payload_empty        = 1'b0;
        o_res.match_rssi           = e_rssi;
        o_res.match_address        = e_addr;
        o_res.match_address_kind   = e_kind;
        o_res.match_count          = r_count;
        if (i_valid) begin
            if (e_phase == PH_CO_HI && co_match && e_flen == ADM_MIN_MANUF_LEN) begin
                o_res_valid         = 1'b1;
                o_res.payload_last  = 1'b1;
                o_res.payload_empty = 1'b1;
                o_res.match_count   = r_count + 32'd1;
            end else if (e_phase == PH_PAYLOAD) begin
                o_res_valid         = 1'b1;
                o_res.payload_byte  = b;
                o_res.payload_index = e_foff - ADM_MIN_MANUF_LEN;
                o_res.payload_last  = (foff_inc >= e_flen);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mfr_id <= '0;
            r_left   <= '0;
            r_phase  <= PH_IDLE;
            r_flen   <= '0;
            r_foff   <= '0;
            r_colo   <= '0;
            r_rssi   <= '0;
            r_addr   <= '0;
            r_kind   <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mfr_id <= i_cfg_wdata;
            end
            r_left  <= n_left;
            r_phase <= n_phase;
            r_flen  <= n_flen;
            r_foff  <= n_foff;
            r_colo  <= n_colo;
            r_rssi  <= n_rssi;
            r_addr  <= n_addr;
            r_kind  <= n_kind;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/adm_queue.sv -----
// ----------------------------------------------------------------------------
// adm_queue
// Back end: small result queue that holds beats until the consumer pops them.
// ----------------------------------------------------------------------------
module adm_queue #(
    parameter int DEPTH = adm_pkg::ADM_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  adm_pkg::t_adm_out i_wdata,
    output logic              o_full,
    input  logic              i_rd,
    output logic              o_empty,
    output adm_pkg::t_adm_out o_rdata
);
    import adm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_adm_out        r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_cnt;
    logic            wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/ad_manufacturer_data_filter.sv -----
// Each result beat is formed combinationally from its accepted byte and written into the result queue.
// Throughput: one report byte per cycle while full is low; the parser never stalls on its own.
// full rises only when all QUEUE_DEPTH result entries wait to be popped.
// Reset (i_rst_n low, synchronous) empties the queue, clears the match count
// and company id, and leaves the parser idle until a first-byte beat.
// ----------------------------------------------------------------------------
// ad_manufacturer_data_filter
// Finds the first manufacturer-specific AD structure with the configured
// company id in each complete advertising report and streams its payload.
// ----------------------------------------------------------------------------
module ad_manufacturer_data_filter #(
    parameter int QUEUE_DEPTH = adm_pkg::ADM_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input, queue style
    input  logic              push,
    output logic              full,
    input  adm_pkg::t_adm_in  i_item,
    // result output, queue style
    output logic              empty,
    input  logic              pop,
    output adm_pkg::t_adm_out o_result,
    // company id register
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata
);
    import adm_pkg::*;

    logic     accept;
    logic     res_valid;
    t_adm_out res;

    // A beat is taken whenever the queue has room: each byte gives at most
    // one result, so a free entry is all the front end needs.
    assign accept = push && !full;

    // Front end: phase walker, metadata capture, match counter, company id.
    adm_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Back end: result queue, so a stalled consumer does not stop parsing
    // until every entry is occupied.
    adm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (res),
        .o_full  (full),
        .i_rd    (pop),
        .o_empty (empty),
        .o_rdata (o_result)
    );

endmodule
